[rtl/ceb_pkg.sv]
// Shared types and constants for the C escape byte encoder.
// Used by the front end, the queue, the back end and the top level.
package ceb_pkg;

   // Configuration register widths and reset values
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 33;
   localparam int unsigned MASK_W      = 33;

   localparam logic [7:0]        RST_ESCAPE_CHAR_A  = 8'h5C;
   localparam logic [7:0]        RST_ESCAPE_CHAR_B  = 8'h22;
   localparam logic [7:0]        RST_ESCAPE_CHAR_C  = 8'h27;
   localparam logic [1:0]        RST_ESCAPE_COUNT   = 2'd1;
   localparam logic [MASK_W-1:0] RST_EXCEPTION_MASK = '0;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ESCAPE_CHAR_A  = 3'd0,
      CSR_ESCAPE_CHAR_B  = 3'd1,
      CSR_ESCAPE_CHAR_C  = 3'd2,
      CSR_ESCAPE_COUNT   = 3'd3,
      CSR_EXCEPTION_MASK = 3'd4
   } csr_index_type;

   // Character constants
   localparam logic [7:0] BACKSLASH  = 8'h5C;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] PRINT_LOW  = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;
   localparam logic [7:0] CODE_DEL   = 8'h7F;

   // Queue depth default
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // How the back end expands one queued request
   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,   // the byte itself
      KIND_PAIR  = 2'd1,   // backslash, then the byte
      KIND_OCTAL = 2'd2    // backslash, then three octal digits
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

endpackage

[rtl/ceb_front.sv]
// Front end: configuration registers and classification of each request.
// Depends on ceb_pkg; feeds ceb_queue with one entry per accepted request.
module ceb_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ceb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ceb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [7:0]                       in_byte,
   output ceb_pkg::entry_type               entry
);

   logic [7:0]                   escape_char_a_ff, escape_char_a_in;
   logic [7:0]                   escape_char_b_ff, escape_char_b_in;
   logic [7:0]                   escape_char_c_ff, escape_char_c_in;
   logic [1:0]                   escape_count_ff,  escape_count_in;
   logic [ceb_pkg::MASK_W-1:0]   exception_mask_ff, exception_mask_in;

   logic       printable;
   logic       in_escape_set;
   logic       exception;
   logic [7:0] letter;
   logic       has_letter;

   // Register writes; an unknown index is ignored
   always_comb begin
      escape_char_a_in  = escape_char_a_ff;
      escape_char_b_in  = escape_char_b_ff;
      escape_char_c_in  = escape_char_c_ff;
      escape_count_in   = escape_count_ff;
      exception_mask_in = exception_mask_ff;
      if (csr_we) begin
         case (csr_index)
            ceb_pkg::CSR_ESCAPE_CHAR_A:  escape_char_a_in  = csr_wdata[7:0];
            ceb_pkg::CSR_ESCAPE_CHAR_B:  escape_char_b_in  = csr_wdata[7:0];
            ceb_pkg::CSR_ESCAPE_CHAR_C:  escape_char_c_in  = csr_wdata[7:0];
            ceb_pkg::CSR_ESCAPE_COUNT:   escape_count_in   = csr_wdata[1:0];
            ceb_pkg::CSR_EXCEPTION_MASK: exception_mask_in = csr_wdata[ceb_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_char_a_ff  <= ceb_pkg::RST_ESCAPE_CHAR_A;
         escape_char_b_ff  <= ceb_pkg::RST_ESCAPE_CHAR_B;
         escape_char_c_ff  <= ceb_pkg::RST_ESCAPE_CHAR_C;
         escape_count_ff   <= ceb_pkg::RST_ESCAPE_COUNT;
         exception_mask_ff <= ceb_pkg::RST_EXCEPTION_MASK;
      end else begin
         escape_char_a_ff  <= escape_char_a_in;
         escape_char_b_ff  <= escape_char_b_in;
         escape_char_c_ff  <= escape_char_c_in;
         escape_count_ff   <= escape_count_in;
         exception_mask_ff <= exception_mask_in;
      end
   end

   // Short escape letters
   always_comb begin
      has_letter = 1'b1;
      case (in_byte)
         8'h0A:   letter = 8'h6E;   // n
         8'h09:   letter = 8'h74;   // t
         8'h0C:   letter = 8'h66;   // f
         8'h0B:   letter = 8'h76;   // v
         8'h0D:   letter = 8'h72;   // r
         8'h07:   letter = 8'h61;   // a
         8'h08:   letter = 8'h62;   // b
         default: begin
            letter     = in_byte;
            has_letter = 1'b0;
         end
      endcase
   end

   // Classification
   assign printable = (in_byte >= ceb_pkg::PRINT_LOW) && (in_byte <= ceb_pkg::PRINT_HIGH);

   assign in_escape_set = ((escape_count_ff >= 2'd1) && (in_byte == escape_char_a_ff))
                       || ((escape_count_ff >= 2'd2) && (in_byte == escape_char_b_ff))
                       || ((escape_count_ff == 2'd3) && (in_byte == escape_char_c_ff));

   // Control codes use their own mask bit, delete uses the top bit
   assign exception = ((in_byte[7:5] == 3'b000) && exception_mask_ff[in_byte[4:0]])
                   || ((in_byte == ceb_pkg::CODE_DEL) && exception_mask_ff[ceb_pkg::MASK_W-1]);

   always_comb begin
      entry.data = in_byte;
      if (printable) begin
         entry.kind = in_escape_set ? ceb_pkg::KIND_PAIR : ceb_pkg::KIND_PLAIN;
      end else if (exception) begin
         entry.kind = ceb_pkg::KIND_PLAIN;
      end else if (has_letter) begin
         entry.kind = ceb_pkg::KIND_PAIR;
         entry.data = letter;
      end else begin
         entry.kind = ceb_pkg::KIND_OCTAL;
      end
   end

endmodule

[rtl/ceb_queue.sv]
// Short queue of classified requests between front and back end.
// Depends on ceb_pkg for the entry type.
module ceb_queue #(
   parameter int unsigned DEPTH = ceb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ceb_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output ceb_pkg::entry_type head_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ceb_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/ceb_back.sv]
// Back end: expands the queue head into one to four response bytes.
// Depends on ceb_pkg; pops ceb_queue on the final byte of each run.
module ceb_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ceb_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   logic [1:0] step_ff, step_in;
   logic       beat;

   assign rsp_tvalid = head_valid;
   assign beat       = rsp_tvalid && rsp_tready;
   assign pop        = beat && rsp_tlast;

   // Byte select and end of run
   always_comb begin
      rsp_tdata = ceb_pkg::BACKSLASH;
      rsp_tlast = 1'b0;
      case (head_entry.kind)
         ceb_pkg::KIND_PLAIN: begin
            rsp_tdata = head_entry.data;
            rsp_tlast = 1'b1;
         end
         ceb_pkg::KIND_PAIR: begin
            if (step_ff != 2'd0) begin
               rsp_tdata = head_entry.data;
               rsp_tlast = 1'b1;
            end
         end
         ceb_pkg::KIND_OCTAL: begin
            case (step_ff)
               2'd1:    rsp_tdata = ceb_pkg::DIGIT_ZERO | {6'b0, head_entry.data[7:6]};
               2'd2:    rsp_tdata = ceb_pkg::DIGIT_ZERO | {5'b0, head_entry.data[5:3]};
               2'd3: begin
                  rsp_tdata = ceb_pkg::DIGIT_ZERO | {5'b0, head_entry.data[2:0]};
                  rsp_tlast = 1'b1;
               end
               default: rsp_tdata = ceb_pkg::BACKSLASH;
            endcase
         end
         default: begin
            rsp_tdata = head_entry.data;
            rsp_tlast = 1'b1;
         end
      endcase
   end

   // Position within the current run
   always_comb begin
      step_in = step_ff;
      if (beat) begin
         step_in = rsp_tlast ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/c_escape_byte_encoder.sv]
// C escape byte encoder: each request byte becomes its C-escaped form as a
// run of one, two or four response bytes, tlast marking the final one. The
// front end classifies a byte in the cycle it is accepted and writes it to a
// queue of QUEUE_DEPTH entries; the back end sends one response byte per
// cycle while rsp_tready is high, the throughput set by the single output
// byte lane; from an empty queue the first comes the cycle after acceptance.
// Requests take one byte, two (backslash and character or letter) or four
// (backslash and three octal digits). Plain bytes stream likewise at one
// request per cycle, given QUEUE_DEPTH >= 2. The user must write configuration
// through the csr_ port only while the block is idle; this is not enforced.
// Depends on ceb_pkg, ceb_front, ceb_queue and ceb_back.
module c_escape_byte_encoder #(
   parameter int unsigned QUEUE_DEPTH = ceb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ceb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ceb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast    // out_last
);

   ceb_pkg::entry_type push_entry;
   ceb_pkg::entry_type head_entry;
   logic               full;
   logic               head_valid;
   logic               pop;

   assign req_tready = !full;

   ceb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_byte   (req_tdata),
      .entry     (push_entry)
   );

   ceb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ceb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sim/c_escape_byte_encoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for c_escape_byte_encoder: directed and random request bytes
// are checked against an in-bench escape predictor, under several register settings.
// Depends on ceb_pkg and the c_escape_byte_encoder RTL.
module c_escape_byte_encoder_tb;

   // Spare register index, outside the register map; writes to it are dropped
   localparam logic [ceb_pkg::CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 3'd7;
   localparam int unsigned                     SETTLE_CYCLES   = 8;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } escaped_byte_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [ceb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ceb_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = '0;   // [7:0] in_byte
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;        // [7:0] out_byte
   logic                            rsp_tlast;        // out_last

   // Predictor copy of the registers
   logic [7:0]                 esc_char_a = ceb_pkg::RST_ESCAPE_CHAR_A;
   logic [7:0]                 esc_char_b = ceb_pkg::RST_ESCAPE_CHAR_B;
   logic [7:0]                 esc_char_c = ceb_pkg::RST_ESCAPE_CHAR_C;
   logic [1:0]                 esc_count  = ceb_pkg::RST_ESCAPE_COUNT;
   logic [ceb_pkg::MASK_W-1:0] pass_mask  = ceb_pkg::RST_EXCEPTION_MASK;

   escaped_byte_type escaped_bytes_due[$];
   int sender_idle_pct   = 6;
   int receiver_idle_pct = 78;
   int mismatch_count    = 0;
   int requests_sent     = 0;
   int bytes_checked     = 0;
   int csr_writes        = 0;

   c_escape_byte_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor: queue the escaped run for one request byte
   function automatic void encode_byte(input logic [7:0] c);
      logic [7:0] letter;
      logic       escaped;
      logic       passes;
      escaped = (esc_count >= 2'd1 && c == esc_char_a) ||
                (esc_count >= 2'd2 && c == esc_char_b) ||
                (esc_count >= 2'd3 && c == esc_char_c);
      passes  = (c < 8'h20) ? pass_mask[c[4:0]] :
                (c == ceb_pkg::CODE_DEL) ? pass_mask[32] : 1'b0;
      case (c)
         8'h0A:   letter = "n";
         8'h09:   letter = "t";
         8'h0C:   letter = "f";
         8'h0B:   letter = "v";
         8'h0D:   letter = "r";
         8'h07:   letter = "a";
         8'h08:   letter = "b";
         default: letter = 8'h00;
      endcase
      if (c >= ceb_pkg::PRINT_LOW && c <= ceb_pkg::PRINT_HIGH) begin
         if (escaped) escaped_bytes_due.push_back('{ceb_pkg::BACKSLASH, 1'b0});
         escaped_bytes_due.push_back('{c, 1'b1});
      end else if (passes) begin
         escaped_bytes_due.push_back('{c, 1'b1});
      end else if (letter != 8'h00) begin
         escaped_bytes_due.push_back('{ceb_pkg::BACKSLASH, 1'b0});
         escaped_bytes_due.push_back('{letter, 1'b1});
      end else begin
         escaped_bytes_due.push_back('{ceb_pkg::BACKSLASH, 1'b0});
         escaped_bytes_due.push_back('{ceb_pkg::DIGIT_ZERO + {6'd0, c[7:6]}, 1'b0});
         escaped_bytes_due.push_back('{ceb_pkg::DIGIT_ZERO + {5'd0, c[5:3]}, 1'b0});
         escaped_bytes_due.push_back('{ceb_pkg::DIGIT_ZERO + {5'd0, c[2:0]}, 1'b1});
      end
   endfunction

   // Receiver: random back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Response checker against the oldest expected byte
   always @(posedge clock) begin
      escaped_byte_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (escaped_bytes_due.size() == 0) begin
            $display("%0t: unexpected response byte %h last %b", $time, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            due = escaped_bytes_due.pop_front();
            if (rsp_tdata !== due.data) begin
               $display("%0t: out_byte mismatch, expected %h, actual %h",
                        $time, due.data, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== due.last) begin
               $display("%0t: out_last mismatch, expected %b, actual %b",
                        $time, due.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Send one request, with an optional random gap in front of it
   task automatic send_byte(input logic [7:0] raw);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      encode_byte(raw);
      requests_sent++;
   endtask

   // Hold off until every expected byte has come out, then let the pipe settle
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (escaped_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ceb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ceb_pkg::CSR_DATA_W-1:0]  value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ceb_pkg::CSR_ESCAPE_CHAR_A:  esc_char_a = value[7:0];
         ceb_pkg::CSR_ESCAPE_CHAR_B:  esc_char_b = value[7:0];
         ceb_pkg::CSR_ESCAPE_CHAR_C:  esc_char_c = value[7:0];
         ceb_pkg::CSR_ESCAPE_COUNT:   esc_count  = value[1:0];
         ceb_pkg::CSR_EXCEPTION_MASK: pass_mask  = value[ceb_pkg::MASK_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // Escape character: mostly printable, now and then any byte
   function automatic logic [7:0] pick_escape_char();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(ceb_pkg::PRINT_LOW, ceb_pkg::PRINT_HIGH));
   endfunction

   // Bias request bytes towards the interesting classes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 8'($urandom_range(0, 255));
         4, 5:       return ($urandom_range(0, 2) == 0) ? esc_char_a :
                            ($urandom_range(0, 1) == 0) ? esc_char_b : esc_char_c;
         6, 7:       return ($urandom_range(0, 8) == 0) ? ceb_pkg::CODE_DEL :
                                                          8'($urandom_range(0, 31));
         default:    return 8'($urandom_range(ceb_pkg::PRINT_LOW, ceb_pkg::PRINT_HIGH));
      endcase
   endfunction

   // Reset values: every escape form, plain bytes at the printable limits
   task automatic test_reset_encoding();
      logic [7:0] bytes[] = '{8'h00, 8'h5C, 8'h22, 8'h27, 8'h41, 8'h20, 8'h7E, 8'h7F,
                              8'h80, 8'hFF, 8'h0A, 8'h09, 8'h0C, 8'h0B, 8'h0D, 8'h07, 8'h08};
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // All three escape characters, one of them unprintable so it never matches
   task automatic test_escape_set();
      wait_until_drained();
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_A, 33'h20);
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_B, 33'h7E);
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_C, 33'h0A);
      write_csr(ceb_pkg::CSR_ESCAPE_COUNT, 33'd3);
      send_byte(8'h20);
      send_byte(8'h7E);
      send_byte(8'h0A);
      send_byte(8'h5C);
      // a write to an unmapped index must leave the escape set alone
      wait_until_drained();
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_A, 33'hFF);
      write_csr(CSR_INDEX_SPARE, '0);
      send_byte(8'hFF);
      send_byte(8'h20);
   endtask

   // Exception mask: full mask lets control codes and DEL through, never high bytes
   task automatic test_exception_mask();
      wait_until_drained();
      write_csr(ceb_pkg::CSR_EXCEPTION_MASK, {ceb_pkg::CSR_DATA_W{1'b1}});
      send_byte(8'h00);
      send_byte(8'h0A);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'h1F);
      wait_until_drained();
      write_csr(ceb_pkg::CSR_EXCEPTION_MASK, 33'h1_0000_0000);
      send_byte(8'h7F);
      send_byte(8'h00);
   endtask

   // Random phase: fresh register set, then biased random requests
   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input logic [1:0] count, input int n_requests);
      logic [ceb_pkg::MASK_W-1:0] mask;
      wait_until_drained();
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      case ($urandom_range(0, 3))
         0:       mask = '0;
         1:       mask = '1;
         default: mask = {1'($urandom_range(0, 1)), 32'($urandom())};
      endcase
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_A, 33'(pick_escape_char()));
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_B, 33'(pick_escape_char()));
      write_csr(ceb_pkg::CSR_ESCAPE_CHAR_C, 33'(pick_escape_char()));
      write_csr(ceb_pkg::CSR_ESCAPE_COUNT, 33'(count));
      write_csr(ceb_pkg::CSR_EXCEPTION_MASK, 33'(mask));
      for (int i = 0; i < n_requests; i++) begin
         if ($urandom_range(0, 24) == 0) wait_until_drained();
         send_byte(pick_byte());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_encoding();
      test_escape_set();
      test_exception_mask();
      test_random_phase(6, 78, 2'd3, 80);
      test_random_phase(78, 6, 2'd0, 80);
      test_random_phase(0, 0, 2'($urandom_range(1, 2)), 80);
      wait_until_drained();
      $display("Sent %0d request bytes and checked %0d response bytes", requests_sent,
               bytes_checked);
      $display("across %0d register writes and three idle/back-pressure mixes", csr_writes);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timed out with %0d response bytes outstanding", escaped_bytes_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
